>>> rtl/core/keyword_redaction_masker_assert.svh
// Assertion macros for the keyword masker RTL, included by krm_cell.
`ifndef KEYWORD_REDACTION_MASKER_ASSERT_SVH
`define KEYWORD_REDACTION_MASKER_ASSERT_SVH

// Condition must never be true while out of reset.
`define KRM_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define KRM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/krm_pkg.sv
// Shared constants and types for the keyword masker.
package krm_pkg;

    localparam int NUM_WORDS      = 6;
    localparam int MAX_WORD_LEN   = 8;
    localparam int CHAR_W         = 8;
    localparam int WORD_W         = MAX_WORD_LEN * CHAR_W;
    localparam int FILL_W         = $clog2(MAX_WORD_LEN);
    localparam int LEN_W          = $clog2(MAX_WORD_LEN + 1);
    localparam int COUNT_W        = $clog2(NUM_WORDS + 1);
    localparam int CFG_IDX_W      = $clog2(NUM_WORDS + 1);
    localparam int CFG_DATA_W     = WORD_W;

    localparam logic [CHAR_W-1:0] MASK_CHAR = 8'h23;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT = CFG_IDX_W'(0);
    localparam int                   REG_WORD_FIRST = 1;

    typedef struct packed {
        logic              last;
        logic [CHAR_W-1:0] chr;
    } t_item;

    typedef struct packed {
        logic              active;
        logic [WORD_W-1:0] word;
    } t_word_cfg;

endpackage

>>> rtl/core/keyword_redaction_masker.sv
// Top level: config registers, uppercase front end and the chain of keyword cells.
// Path: one output register per cell, NUM_WORDS (6) cells in the chain; each active
//   cell also holds up to (keyword length - 1) bytes until more text or the last byte.
// Throughput: one transaction per cycle while downstream is ready; after a last byte each
//   cell drains its window one byte per cycle while its output is free, stalling its input.
// Reset (synchronous, active low): clears config, fill counts, blocks, flushes, valids.
module keyword_redaction_masker import krm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] in_char
    input  logic                  s_axis_tlast,   // in_last
    // output stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [7:0] out_char
    output logic                  m_axis_tlast    // out_last
);

    // Configuration registers; the word count takes the low COUNT_W data bits, saturated at the number of cells.
    logic [COUNT_W-1:0] r_word_count;
    logic [WORD_W-1:0]  r_words [NUM_WORDS];
    logic [COUNT_W-1:0] cnt_wr;

    assign cnt_wr = (i_cfg_data[COUNT_W-1:0] > COUNT_W'(NUM_WORDS))
                  ? COUNT_W'(NUM_WORDS) : i_cfg_data[COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count <= '0;
            for (int s = 0; s < NUM_WORDS; s++) begin
                r_words[s] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WORD_COUNT) begin
                r_word_count <= cnt_wr;
            end
            for (int s = 0; s < NUM_WORDS; s++) begin
                if (i_cfg_idx == CFG_IDX_W'(REG_WORD_FIRST + s)) begin
                    r_words[s] <= i_cfg_data[WORD_W-1:0];
                end
            end
        end
    end

    // Links between cells: index 0 is the block input, NUM_WORDS the block output.
    logic  link_valid [NUM_WORDS+1];
    logic  link_ready [NUM_WORDS+1];
    t_item link_item  [NUM_WORDS+1];

    // Lowercase ASCII letters become uppercase before the first cell.
    assign link_item[0].last = s_axis_tlast;
    assign link_item[0].chr  = (s_axis_tdata >= 8'h61 && s_axis_tdata <= 8'h7A)
                             ? s_axis_tdata - 8'h20 : s_axis_tdata;

    assign link_valid[0]         = s_axis_tvalid;
    assign s_axis_tready         = link_ready[0];
    assign link_ready[NUM_WORDS] = m_axis_tready;

    for (genvar s = 0; s < NUM_WORDS; s++) begin : g_cell
        t_word_cfg cell_cfg;

        // A cell at or above the word count only passes text on.
        assign cell_cfg.active = (COUNT_W'(s) < r_word_count);
        assign cell_cfg.word   = r_words[s];

        krm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cfg      (cell_cfg),
            .i_up_valid (link_valid[s]),
            .o_up_ready (link_ready[s]),
            .i_up_item  (link_item[s]),
            .o_dn_valid (link_valid[s+1]),
            .i_dn_ready (link_ready[s+1]),
            .o_dn_item  (link_item[s+1])
        );
    end

    assign m_axis_tvalid = link_valid[NUM_WORDS];
    assign m_axis_tdata  = link_item[NUM_WORDS].chr;
    assign m_axis_tlast  = link_item[NUM_WORDS].last;

endmodule

>>> rtl/core/krm_cell.sv
// One keyword stage: sliding window, match and mask, registered output.
`include "keyword_redaction_masker_assert.svh"

module krm_cell import krm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_word_cfg i_cfg,
    input  logic      i_up_valid,
    output logic      o_up_ready,
    input  t_item     i_up_item,
    output logic      o_dn_valid,
    input  logic      i_dn_ready,
    output t_item     o_dn_item
);

    function automatic logic [LEN_W-1:0] word_len(input logic [WORD_W-1:0] w);
        logic [LEN_W-1:0] n;
        logic             stop;
        n    = '0;
        stop = 1'b0;
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
            if (w[k*CHAR_W +: CHAR_W] == '0) begin
                stop = 1'b1;
            end else if (!stop) begin
                n = n + LEN_W'(1);
            end
        end
        return n;
    endfunction

    logic [CHAR_W-1:0] r_win [MAX_WORD_LEN];
    logic [CHAR_W-1:0] n_win [MAX_WORD_LEN];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [FILL_W-1:0] r_bl, n_bl;
    logic              r_flush, n_flush;
    logic              r_ovalid;
    t_item             r_oitem;

    logic [LEN_W-1:0]  len, eff, fill_x, fill_app;
    logic              out_free, drain, take, full, hit, match_ok;
    logic              emit;
    t_item             emit_item;
    logic [CHAR_W-1:0] w_app   [MAX_WORD_LEN];
    logic [CHAR_W-1:0] w_msk   [MAX_WORD_LEN];
    logic [CHAR_W-1:0] src     [MAX_WORD_LEN];
    logic [CHAR_W-1:0] shifted [MAX_WORD_LEN];

    always_comb begin
        len      = i_cfg.active ? word_len(i_cfg.word) : '0;
        eff      = (len == '0) ? LEN_W'(1) : len;
        fill_x   = LEN_W'(r_fill);
        fill_app = fill_x + LEN_W'(1);
        full     = (fill_app == eff);
        out_free = !r_ovalid || i_dn_ready;
        // flushing at message end, or window at or over the word length after a config change
        drain    = r_flush || (fill_x >= eff);
        take     = i_up_valid && out_free && !drain;

        match_ok = 1'b1;
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
            w_app[k] = (FILL_W'(k) == r_fill) ? i_up_item.chr : r_win[k];
            if (LEN_W'(k) < len && w_app[k] != i_cfg.word[k*CHAR_W +: CHAR_W]) begin
                match_ok = 1'b0;
            end
        end
        hit = (len != '0) && (r_bl == '0) && match_ok;

        for (int k = 0; k < MAX_WORD_LEN; k++) begin
            w_msk[k] = (hit && LEN_W'(k) < len) ? MASK_CHAR : w_app[k];
            src[k]   = drain ? r_win[k] : w_msk[k];
        end
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
            shifted[k] = (k < MAX_WORD_LEN - 1) ? src[(k + 1) % MAX_WORD_LEN] : '0;
        end
    end

    assign o_up_ready = out_free && !drain;

    always_comb begin
        n_win          = r_win;
        n_fill         = r_fill;
        n_bl           = r_bl;
        n_flush        = r_flush;
        emit           = 1'b0;
        emit_item.chr  = src[0];
        emit_item.last = 1'b0;
        if (out_free) begin
            if (drain) begin
                emit   = 1'b1;
                n_win  = shifted;
                n_fill = r_fill - FILL_W'(1);
                n_bl   = (r_bl != '0) ? r_bl - FILL_W'(1) : '0;
                if (r_flush && r_fill == FILL_W'(1)) begin
                    emit_item.last = 1'b1;
                    n_flush        = 1'b0;
                end
            end else if (take) begin
                if (full) begin
                    emit   = 1'b1;
                    n_win  = shifted;
                    n_fill = r_fill;
                    if (hit) begin
                        n_bl = FILL_W'(len - LEN_W'(1));
                    end else begin
                        n_bl = (r_bl != '0) ? r_bl - FILL_W'(1) : '0;
                    end
                end else begin
                    n_win  = w_app;
                    n_fill = r_fill + FILL_W'(1);
                end
                if (i_up_item.last) begin
                    n_bl = '0;
                    if (full && r_fill == '0) begin
                        emit_item.last = 1'b1;
                    end else begin
                        n_flush = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (out_free) begin
            r_oitem <= emit_item;
        end
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_bl     <= '0;
            r_flush  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_bl    <= n_bl;
            r_flush <= n_flush;
            if (out_free) begin
                r_ovalid <= emit;
            end
        end
    end

    assign o_dn_valid = r_ovalid;
    assign o_dn_item  = r_oitem;

    `KRM_ASSERT_NEVER(a_flush_nonempty, i_clk, i_rst_n, r_flush && r_fill == '0, "flush with empty window")
    `KRM_ASSERT_NEVER(a_block_within_fill, i_clk, i_rst_n, r_bl > r_fill, "match block exceeds window")
    `KRM_ASSERT_NEXT(a_flush_emits, i_clk, i_rst_n, r_flush && out_free, r_ovalid, "flush cycle gave no output")

endmodule
